// ===== src/transfer_watchdog_generation_fence_defines.svh =====
// Assertion macros for the transfer watchdog RTL.
`ifndef TRANSFER_WATCHDOG_GENERATION_FENCE_DEFINES_SVH
`define TRANSFER_WATCHDOG_GENERATION_FENCE_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent checked in the cycle after the antecedent.
`define TWGF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
// Consequent checked in the same cycle as the antecedent.
`define TWGF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define TWGF_ASSERT_NEXT(label, ante, cons, msg)
`define TWGF_ASSERT_NOW(label, ante, cons, msg)
`endif
`endif

// ===== src/twgf_pkg.sv =====
// Package with types, codes and widths of the transfer watchdog.
`default_nettype none
package twgf_pkg;

	localparam int NOW_W      = 32;
	localparam int TOTAL_W    = 32;
	localparam int XFER_W     = 31;
	localparam int TAG_W      = 16;
	localparam int OWNER_W    = 2;
	localparam int SITE_W     = 2;
	localparam int OP_W       = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int DEF_GEN_BITS = 16;

	// Register reset values
	localparam logic [NOW_W-1:0] MAX_DURATION_RST = 32'd7200;
	localparam logic [NOW_W-1:0] STALL_RST        = 32'd900;
	localparam logic signed [TOTAL_W-1:0] TOTAL_UNKNOWN = -32'sd1;

	// Opcodes
	localparam logic [OP_W-1:0] OP_BEGIN    = 3'd0;
	localparam logic [OP_W-1:0] OP_PROGRESS = 3'd1;
	localparam logic [OP_W-1:0] OP_END      = 3'd2;
	localparam logic [OP_W-1:0] OP_CANCEL   = 3'd3;
	localparam logic [OP_W-1:0] OP_CHECK    = 3'd4;
	localparam logic [OP_W-1:0] OP_RELEASE  = 3'd5;

	// Owners
	localparam logic [OWNER_W-1:0] OWNER_NONE    = 2'd0;
	localparam logic [OWNER_W-1:0] OWNER_CATALOG = 2'd1;
	localparam logic [OWNER_W-1:0] OWNER_BULK    = 2'd2;

	// Check sites
	localparam logic [SITE_W-1:0] SITE_ORCH    = 2'd0;
	localparam logic [SITE_W-1:0] SITE_CHART   = 2'd1;
	localparam logic [SITE_W-1:0] SITE_CATALOG = 2'd2;

	// Stuck reasons
	localparam logic [1:0] REASON_NONE     = 2'd0;
	localparam logic [1:0] REASON_DURATION = 2'd1;
	localparam logic [1:0] REASON_STALL    = 2'd2;

	// Reactions
	localparam logic [1:0] REACT_NONE          = 2'd0;
	localparam logic [1:0] REACT_PUMP          = 2'd1;
	localparam logic [1:0] REACT_ABORT_CHART   = 2'd2;
	localparam logic [1:0] REACT_ABORT_CATALOG = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DURATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL        = 2'd1;

	typedef struct packed {
		logic [OP_W-1:0]           opcode;
		logic [NOW_W-1:0]          now_seconds;
		logic [OWNER_W-1:0]        owner_in;
		logic signed [TOTAL_W-1:0] total_bytes;
		logic [XFER_W-1:0]         transferred_bytes;
		logic [TAG_W-1:0]          generation_tag;
		logic                      ok;
		logic [SITE_W-1:0]         site;
	} req_item_t;

	typedef struct packed {
		logic                      accepted;
		logic                      in_progress;
		logic                      complete_flag;
		logic                      success_flag;
		logic [OWNER_W-1:0]        owner_out;
		logic [TAG_W-1:0]          generation_out;
		logic [XFER_W-1:0]         transferred_out;
		logic signed [TOTAL_W-1:0] total_out;
		logic [1:0]                stuck_reason;
		logic [1:0]                reaction;
	} rsp_item_t;

	typedef struct packed {
		logic [NOW_W-1:0] max_duration_seconds;
		logic [NOW_W-1:0] stall_seconds;
	} limits_t;

endpackage
`default_nettype wire

// ===== src/twgf_cfg.sv =====
// Configuration registers for the watchdog time limits.
`default_nettype none
module twgf_cfg import twgf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output limits_t                    limits
);

	logic [NOW_W-1:0] max_duration_q;
	logic [NOW_W-1:0] stall_q;

	// Writes are taken at any time
	assign cfg_ready = 1'b1;

	// Register write decode; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duration_q <= MAX_DURATION_RST;
			stall_q        <= STALL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_DURATION: max_duration_q <= cfg_data[NOW_W-1:0];
				CFG_STALL:        stall_q        <= cfg_data[NOW_W-1:0];
				default: ;
			endcase
		end
	end

	assign limits.max_duration_seconds = max_duration_q;
	assign limits.stall_seconds        = stall_q;

endmodule
`default_nettype wire

// ===== src/twgf_core.sv =====
// Slot state and single-pass event evaluation of the transfer watchdog.
`default_nettype none
`include "transfer_watchdog_generation_fence_defines.svh"
module twgf_core import twgf_pkg::*; #(
	parameter int GEN_BITS = DEF_GEN_BITS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire req_item_t item,
	input  wire limits_t   limits,
	output rsp_item_t      result
);

	localparam int CMP_W = (GEN_BITS > TAG_W) ? GEN_BITS : TAG_W;

	logic [OWNER_W-1:0]        owner_q, owner_d;
	logic                      complete_q, complete_d;
	logic                      success_q, success_d;
	logic signed [TOTAL_W-1:0] total_q, total_d;
	logic [XFER_W-1:0]         xfer_q, xfer_d;
	logic [GEN_BITS-1:0]       gen_q, gen_d;
	logic [NOW_W-1:0]          begin_time_q, begin_time_d;
	logic [NOW_W-1:0]          last_prog_q, last_prog_d;

	logic                busy;
	logic                fence_ok;
	logic [GEN_BITS-1:0] gen_inc;
	logic [GEN_BITS-1:0] gen_bump;
	logic [NOW_W-1:0]    since_begin;
	logic [NOW_W-1:0]    since_prog;
	logic                dur_hit;
	logic                stall_hit;
	logic                accepted;
	logic [1:0]          reason;
	logic [1:0]          react;
	logic [CMP_W-1:0]    gen_ext;
	logic [CMP_W-1:0]    tag_ext;
	logic [CMP_W-1:0]    gen_d_ext;

	// Slot status and generation fence
	assign busy     = (owner_q != OWNER_NONE) && !complete_q;
	assign gen_ext  = CMP_W'(gen_q);
	assign tag_ext  = CMP_W'(item.generation_tag);
	assign fence_ok = (owner_q != OWNER_NONE) &&
		((item.generation_tag == '0) || (tag_ext == gen_ext));

	// Generation bump skips zero on wrap
	assign gen_inc  = gen_q + GEN_BITS'(1);
	assign gen_bump = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

	// Elapsed-time limits; a timestamp in the past never counts
	assign since_begin = item.now_seconds - begin_time_q;
	assign since_prog  = item.now_seconds - last_prog_q;
	assign dur_hit   = (item.now_seconds >= begin_time_q) &&
		(since_begin >= limits.max_duration_seconds);
	assign stall_hit = (item.now_seconds >= last_prog_q) &&
		(since_prog >= limits.stall_seconds);

	// Next slot state per opcode
	always_comb begin
		owner_d      = owner_q;
		complete_d   = complete_q;
		success_d    = success_q;
		total_d      = total_q;
		xfer_d       = xfer_q;
		gen_d        = gen_q;
		begin_time_d = begin_time_q;
		last_prog_d  = last_prog_q;
		accepted     = 1'b0;
		reason       = REASON_NONE;
		unique case (item.opcode) inside
			OP_BEGIN: begin
				if (!busy && ((item.owner_in == OWNER_CATALOG) ||
						(item.owner_in == OWNER_BULK))) begin
					owner_d      = item.owner_in;
					complete_d   = 1'b0;
					success_d    = 1'b0;
					total_d      = TOTAL_UNKNOWN;
					xfer_d       = '0;
					gen_d        = gen_bump;
					begin_time_d = item.now_seconds;
					last_prog_d  = item.now_seconds;
					accepted     = 1'b1;
				end
			end
			OP_PROGRESS: begin
				if (fence_ok) begin
					if (item.transferred_bytes > xfer_q) begin
						xfer_d      = item.transferred_bytes;
						last_prog_d = item.now_seconds;
					end
					if (!item.total_bytes[TOTAL_W-1])
						total_d = item.total_bytes;
					accepted = 1'b1;
				end
			end
			OP_END: begin
				if (fence_ok) begin
					complete_d = 1'b1;
					success_d  = item.ok;
					accepted   = 1'b1;
				end
			end
			OP_CANCEL, OP_RELEASE: begin
				owner_d      = OWNER_NONE;
				complete_d   = 1'b0;
				success_d    = 1'b0;
				total_d      = TOTAL_UNKNOWN;
				xfer_d       = '0;
				begin_time_d = '0;
				last_prog_d  = '0;
				if (item.opcode == OP_CANCEL)
					gen_d = gen_bump;
				accepted     = 1'b1;
			end
			OP_CHECK: begin
				if (busy) begin
					if (dur_hit)
						reason = REASON_DURATION;
					else if (stall_hit)
						reason = REASON_STALL;
				end
				accepted = 1'b1;
			end
			default: ;
		endcase
	end

	// Reaction for the calling site
	always_comb begin
		react = REACT_NONE;
		if (reason != REASON_NONE) begin
			case (item.site)
				SITE_ORCH:    react = REACT_PUMP;
				SITE_CHART:   react = REACT_ABORT_CHART;
				SITE_CATALOG: react = REACT_ABORT_CATALOG;
				default:      react = REACT_NONE;
			endcase
		end
	end

	// Low bits of the generation after this event
	assign gen_d_ext = CMP_W'(gen_d);

	// Result reflects the state after this event
	always_comb begin
		result.accepted        = accepted;
		result.in_progress     = (owner_d != OWNER_NONE) && !complete_d;
		result.complete_flag   = complete_d;
		result.success_flag    = success_d;
		result.owner_out       = owner_d;
		result.generation_out  = gen_d_ext[TAG_W-1:0];
		result.transferred_out = xfer_d;
		result.total_out       = total_d;
		result.stuck_reason    = reason;
		result.reaction        = react;
	end

	// Slot state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q      <= OWNER_NONE;
			complete_q   <= 1'b0;
			success_q    <= 1'b0;
			total_q      <= TOTAL_UNKNOWN;
			xfer_q       <= '0;
			gen_q        <= '0;
			begin_time_q <= '0;
			last_prog_q  <= '0;
		end else if (advance) begin
			owner_q      <= owner_d;
			complete_q   <= complete_d;
			success_q    <= success_d;
			total_q      <= total_d;
			xfer_q       <= xfer_d;
			gen_q        <= gen_d;
			begin_time_q <= begin_time_d;
			last_prog_q  <= last_prog_d;
		end
	end

	`TWGF_ASSERT_NEXT(a_cancel_gen_nonzero, advance && (item.opcode == OP_CANCEL), gen_q != '0, "generation is zero after cancel")
	`TWGF_ASSERT_NEXT(a_release_keeps_gen, advance && (item.opcode == OP_RELEASE), $stable(gen_q), "release changed the generation")
	`TWGF_ASSERT_NEXT(a_busy_refuses_begin, advance && (item.opcode == OP_BEGIN) && busy, $stable(owner_q) && $stable(gen_q), "begin taken while busy")
	`TWGF_ASSERT_NEXT(a_xfer_monotonic, advance && ((item.opcode == OP_PROGRESS) || (item.opcode == OP_END)), xfer_q >= $past(xfer_q), "transferred count shrank")

endmodule
`default_nettype wire

// ===== src/transfer_watchdog_generation_fence.sv =====
// An event taken into the input register is evaluated by the core; its result
// is registered when the stage advances, which waits on an undrained result.
// One event per cycle is sustained while rsp_ready stays high, bounded by the
// single state-update pass between the input register and the result register.
// Reset (arst_n low, asynchronous): slot cleared, generation 0,
// limits 7200 s and 900 s; no clearing pass is needed.
`default_nettype none
module transfer_watchdog_generation_fence import twgf_pkg::*; #(
	parameter int GEN_BITS = DEF_GEN_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire req_item_t             req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output rsp_item_t                  rsp,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic      valid_s1;
	req_item_t item_s1;
	logic      rsp_valid_q;
	rsp_item_t rsp_q;
	rsp_item_t result;
	limits_t   limits;
	logic      advance;
	logic      req_fire;

	// Stage moves when the result register is free or being drained
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign req_fire  = req_valid && req_ready;

	twgf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	twgf_core #(
		.GEN_BITS (GEN_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.limits  (limits),
		.result  (result)
	);

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req_fire || (valid_s1 && !advance);
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (req_fire)
			item_s1 <= req;
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance)
			rsp_q <= result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
